>>> design/timed_switch_resistance_profile_assert.svh
// ----------------------------------------------------------------------------
// timed switch resistance profile assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TIMED_SWITCH_RESISTANCE_PROFILE_ASSERT_SVH
`define TIMED_SWITCH_RESISTANCE_PROFILE_ASSERT_SVH

// pre holds now, post holds in the next cycle
`define TSRP_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("lbl failed");

// pre and post hold in the same cycle
`define TSRP_ASSERT_SAME(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("lbl failed");

`endif

>>> design/tsrp_pkg.sv
// ----------------------------------------------------------------------------
// tsrp_pkg
// types and constants of the timed switch resistance profile
// ----------------------------------------------------------------------------
package tsrp_pkg;

  localparam int RES_W  = 52;
  localparam int TIME_W = 48;
  localparam int IVL_W  = 32;
  localparam int DIVN_W = 64;
  localparam int DIVD_W = 48;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [2:0] REG_INIT_ON  = 3'd0;
  localparam logic [2:0] REG_RON      = 3'd1;
  localparam logic [2:0] REG_ROFF     = 3'd2;
  localparam logic [2:0] REG_MODE     = 3'd3;
  localparam logic [2:0] REG_MAX_DUR  = 3'd4;
  localparam logic [2:0] REG_ICOUNT   = 3'd5;

  localparam logic [1:0] MODE_ABRUPT = 2'd0;
  localparam logic [1:0] MODE_LINEAR = 2'd1;

  localparam logic [RES_W-1:0] ROFF_RESET    = 52'd1000000000000000;
  localparam logic [1:0]       MODE_RESET    = 2'd2;
  localparam logic [IVL_W-1:0] MAX_DUR_RESET = 32'd1000000;
  localparam logic [4:0]       ICOUNT_RESET  = 5'd1;
  // floor(n / 100) = (n * RECIP_HUNDRED) >> RECIP_SHIFT for any 32-bit n
  localparam logic [IVL_W-1:0] RECIP_HUNDRED = 32'd1374389535;
  localparam int               RECIP_SHIFT   = 37;

  typedef struct packed {
    logic              op;
    logic [3:0]        index;
    logic [IVL_W-1:0]  interval;
    logic [TIME_W-1:0] time_now;
  } in_word_t;

  typedef struct packed {
    logic [RES_W-1:0] resistance;
    logic             switch_on;
    logic             in_transition;
  } out_word_t;

  typedef enum logic [1:0] {
    DSEL_DUR  = 2'd0,
    DSEL_MOD  = 2'd1,
    DSEL_FRAC = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     cap;
    logic     clr_idx;
    logic     acc_sum;
    logic     acc_walk;
    logic     div_go;
    div_sel_t div_sel;
    logic     set_dur;
    logic     set_mod;
    logic     set_x;
    logic     sq;
    logic     cube;
    logic     sel;
    logic     mul;
    logic     fin;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
    logic fold;
    logic abrupt;
    logic linear;
    logic out_busy;
  } sts_t;

endpackage

>>> design/tsrp_div.sv
// ----------------------------------------------------------------------------
// tsrp_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tsrp_div
  import tsrp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVN_W-1:0] dividend,
  input  logic [DIVD_W-1:0] divisor,
  output logic              done,
  output logic [DIVN_W-1:0] quo,
  output logic [DIVD_W-1:0] rem
);

  localparam int CNT_W = $clog2(DIVN_W);

  logic [DIVN_W-1:0] quo_r;
  logic [DIVD_W-1:0] rem_r;
  logic [DIVD_W-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIVD_W:0]   trial;
  logic              ge;

  assign trial = {rem_r, quo_r[DIVN_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? DIVD_W'(trial - {1'b0, dvs_r}) : trial[DIVD_W-1:0];
        quo_r <= {quo_r[DIVN_W-2:0], ge};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIVN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

>>> design/tsrp_ctrl.sv
// ----------------------------------------------------------------------------
// tsrp_ctrl
// sequencer for table walks, divisions and ramp arithmetic
// ----------------------------------------------------------------------------
module tsrp_ctrl
  import tsrp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_op,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_stall
);

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_SRD   = 16'h0002,
    S_SACC  = 16'h0004,
    S_GDUR  = 16'h0008,
    S_WDUR  = 16'h0010,
    S_GMOD  = 16'h0020,
    S_WMOD  = 16'h0040,
    S_WRD   = 16'h0080,
    S_WACC  = 16'h0100,
    S_GFRAC = 16'h0200,
    S_WFRAC = 16'h0400,
    S_SQ    = 16'h0800,
    S_CUBE  = 16'h1000,
    S_SEL   = 16'h2000,
    S_MUL   = 16'h4000,
    S_FIN   = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = DSEL_DUR;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_op == OP_LOAD) begin
          cmd.load = 1'b1;
        end else if (in_valid) begin
          cmd.cap     = 1'b1;
          cmd.clr_idx = 1'b1;
          state_nxt   = S_SRD;
        end
      end
      S_SRD:  state_nxt = S_SACC;
      S_SACC: begin
        cmd.acc_sum = 1'b1;
        state_nxt   = sts.last ? S_GDUR : S_SRD;
      end
      // reciprocal product of the minimum is registered here
      S_GDUR: state_nxt = S_WDUR;
      S_WDUR: begin
        cmd.set_dur = 1'b1;
        cmd.clr_idx = 1'b1;
        state_nxt   = sts.fold ? S_GMOD : S_WRD;
      end
      S_GMOD: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DSEL_MOD;
        state_nxt   = S_WMOD;
      end
      S_WMOD: begin
        if (sts.div_done) begin
          cmd.set_mod = 1'b1;
          state_nxt   = S_WRD;
        end
      end
      S_WRD:  state_nxt = S_WACC;
      S_WACC: begin
        cmd.acc_walk = 1'b1;
        if (sts.last) begin
          state_nxt = sts.abrupt ? S_FIN : S_GFRAC;
        end else begin
          state_nxt = S_WRD;
        end
      end
      S_GFRAC: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DSEL_FRAC;
        state_nxt   = S_WFRAC;
      end
      S_WFRAC: begin
        if (sts.div_done) begin
          cmd.set_x = 1'b1;
          state_nxt = sts.linear ? S_SEL : S_SQ;
        end
      end
      S_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = S_CUBE;
      end
      S_CUBE: begin
        cmd.cube  = 1'b1;
        state_nxt = S_SEL;
      end
      S_SEL: begin
        cmd.sel   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/tsrp_datapath.sv
// ----------------------------------------------------------------------------
// tsrp_datapath
// settings, interval table, accumulators, ramp arithmetic and result word
// ----------------------------------------------------------------------------
module tsrp_datapath
  import tsrp_pkg::*;
#(
  parameter int MAX_INTERVALS = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_addr,
  input  logic [51:0]     cfg_wdata,
  input  in_word_t        in_word,
  input  cmd_t            cmd,
  output sts_t            sts,
  input  logic            out_stall,
  output logic            out_valid,
  output out_word_t       out_word
);

  localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int SW = IVL_W + CW;
  localparam int XW = FRACTION_BITS + 1;
  localparam int PW = 2 * XW;
  localparam logic [XW-1:0] ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [PW-1:0] HALF = PW'(1) << (FRACTION_BITS - 1);
  localparam logic [8:0]    MAXC = 9'(MAX_INTERVALS);

  // settings
  logic              init_on_r;
  logic [RES_W-1:0]  ron_r, roff_r;
  logic [1:0]        mode_r;
  logic [IVL_W-1:0]  max_dur_r;
  logic [4:0]        icount_r;

  logic [IVL_W-1:0]  mem [MAX_INTERVALS];
  logic [IVL_W-1:0]  rd_r;

  logic [CW-1:0]     idx_r, count_r;
  logic [SW-1:0]     sum_r, ti_r, ts_r;
  logic [IVL_W-1:0]  mn_r, dur_r, tdiff_r, q100_r;
  logic [TIME_W-1:0] t_r;
  logic              on_r, toggled_r, stop_r;
  logic [XW-1:0]     x_r, x2_r, x3_r, s_r;
  logic [RES_W:0]    hi_p_r;
  logic [PW-1:0]     lo_p_r;
  out_word_t         out_r;
  logic              out_valid_r;

  logic [8:0]        ic9;
  logic [8:0]        cnt9;
  logic [SW-1:0]     ti_sum;
  logic [TIME_W-1:0] traw;
  logic [IVL_W-1:0]  tdiff_c;
  logic              div_done;
  logic [DIVN_W-1:0] div_quo, dvn;
  logic [DIVD_W-1:0] div_rem, dvd;
  logic [IVL_W-1:0]  md;
  logic [IVL_W-1:0]  dq1;
  logic [2*IVL_W-1:0] q100_p;
  logic [PW-1:0]     sq_p, cu_p;
  logic [XW+1:0]     t3, t2, sdiff;
  logic [RES_W-1:0]  r1, r0, amag;
  logic              up;
  logic [RES_W:0]    dlt;
  logic [RES_W-1:0]  rres;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_on_r <= 1'b0;
      ron_r     <= '0;
      roff_r    <= ROFF_RESET;
      mode_r    <= MODE_RESET;
      max_dur_r <= MAX_DUR_RESET;
      icount_r  <= ICOUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_INIT_ON: init_on_r <= cfg_wdata[0];
        REG_RON:     ron_r     <= cfg_wdata;
        REG_ROFF:    roff_r    <= cfg_wdata;
        REG_MODE:    mode_r    <= cfg_wdata[1:0];
        REG_MAX_DUR: max_dur_r <= cfg_wdata[IVL_W-1:0];
        REG_ICOUNT:  icount_r  <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && {5'b0, in_word.index} < MAXC) begin
      mem[IW'(in_word.index)] <= in_word.interval;
    end
    rd_r <= mem[idx_r[IW-1:0]];
  end

  // zero count runs as one, large counts saturate
  assign ic9  = {4'b0, icount_r};
  assign cnt9 = (ic9 == 9'd0) ? 9'd1 : ((ic9 > MAXC) ? MAXC : ic9);

  assign ti_sum = ti_r + SW'(rd_r);
  assign traw   = toggled_r ? t_r - TIME_W'(ts_r) : TIME_W'(dur_r);
  assign tdiff_c = (traw > TIME_W'(dur_r)) ? dur_r : traw[IVL_W-1:0];

  always_comb begin
    case (cmd.div_sel)
      DSEL_FRAC: begin
        dvn = DIVN_W'(tdiff_c) << FRACTION_BITS;
        dvd = DIVD_W'(dur_r);
      end
      default: begin
        dvn = DIVN_W'(t_r);
        dvd = DIVD_W'(sum_r);
      end
    endcase
  end

  tsrp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (dvn),
    .divisor  (dvd),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // smallest interval over 100 by reciprocal multiplication
  assign q100_p = (2*IVL_W)'(mn_r) * (2*IVL_W)'(RECIP_HUNDRED);

  assign md  = (max_dur_r == '0) ? IVL_W'(1) : max_dur_r;
  assign dq1 = (q100_r == '0) ? IVL_W'(1) : q100_r;

  assign sq_p = PW'(x_r) * PW'(x_r);
  assign cu_p = PW'(x2_r) * PW'(x_r);
  assign t3   = (XW+2)'(x2_r) * (XW+2)'(3);
  assign t2   = (XW+2)'(x3_r) << 1;
  assign sdiff = t3 - t2;

  assign r1   = on_r ? ron_r : roff_r;
  assign r0   = on_r ? roff_r : ron_r;
  assign up   = r1 >= r0;
  assign amag = up ? r1 - r0 : r0 - r1;
  assign dlt  = hi_p_r + (RES_W+1)'((lo_p_r + HALF) >> FRACTION_BITS);
  assign rres = up ? RES_W'(r0 + dlt[RES_W-1:0]) : RES_W'(r0 - dlt[RES_W-1:0]);

  always_ff @(posedge clk) begin
    q100_r <= IVL_W'(q100_p >> RECIP_SHIFT);
    if (cmd.clr_idx) begin
      idx_r <= '0;
    end else if (cmd.acc_sum || cmd.acc_walk) begin
      idx_r <= idx_r + CW'(1);
    end
    if (cmd.cap) begin
      t_r       <= in_word.time_now;
      count_r   <= CW'(cnt9);
      sum_r     <= '0;
      mn_r      <= '1;
      ti_r      <= '0;
      ts_r      <= '0;
      on_r      <= init_on_r;
      toggled_r <= 1'b0;
      stop_r    <= 1'b0;
    end
    if (cmd.acc_sum) begin
      sum_r <= sum_r + SW'(rd_r);
      if (rd_r < mn_r) mn_r <= rd_r;
    end
    if (cmd.set_dur) begin
      dur_r <= (dq1 > md) ? md : dq1;
    end
    if (cmd.set_mod) begin
      t_r <= TIME_W'(div_rem);
    end
    // walk stops at the first running sum still in the future
    if (cmd.acc_walk && !stop_r) begin
      ti_r <= ti_sum;
      if (t_r >= TIME_W'(ti_sum)) begin
        on_r      <= ~on_r;
        ts_r      <= ti_sum;
        toggled_r <= 1'b1;
      end else begin
        stop_r <= 1'b1;
      end
    end
    if (cmd.div_go && cmd.div_sel == DSEL_FRAC) begin
      tdiff_r <= tdiff_c;
    end
    if (cmd.set_x) begin
      x_r <= div_quo[XW-1:0];
    end
    if (cmd.sq) begin
      x2_r <= XW'((sq_p + HALF) >> FRACTION_BITS);
    end
    if (cmd.cube) begin
      x3_r <= XW'((cu_p + HALF) >> FRACTION_BITS);
    end
    if (cmd.sel) begin
      if (mode_r == MODE_LINEAR) begin
        s_r <= x_r;
      end else if (t3 < t2 || sdiff > (XW+2)'(ONE)) begin
        s_r <= ONE;
      end else begin
        s_r <= sdiff[XW-1:0];
      end
    end
    if (cmd.mul) begin
      hi_p_r <= (RES_W+1)'(amag[RES_W-1:FRACTION_BITS]) * (RES_W+1)'(s_r);
      lo_p_r <= PW'(amag[FRACTION_BITS-1:0]) * PW'(s_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_r.switch_on <= on_r;
      if (mode_r == MODE_ABRUPT) begin
        out_r.resistance    <= r1;
        out_r.in_transition <= 1'b0;
      end else begin
        out_r.resistance    <= rres;
        out_r.in_transition <= tdiff_r < dur_r;
      end
    end
  end

  assign sts.last     = (idx_r + CW'(1)) == count_r;
  assign sts.div_done = div_done;
  assign sts.fold     = !count_r[0] && sum_r != '0;
  assign sts.abrupt   = mode_r == MODE_ABRUPT;
  assign sts.linear   = mode_r == MODE_LINEAR;
  assign sts.out_busy = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

>>> design/timed_switch_resistance_profile.sv
// ----------------------------------------------------------------------------
// timed_switch_resistance_profile
// switch resistance against time from a table of switching intervals
// ----------------------------------------------------------------------------
// channel  direction  word          handshake
// in_      input      in_word_t     in_valid / in_stall
// out_     output     out_word_t    out_valid / out_stall
// cfg_     input      52-bit data   cfg_we, cfg_addr
//
// a load word leaves the input free for the next word; an evaluate word sums
// the table, divides for a modulo when the count N is even and the interval
// sum non-zero, walks the table again and, unless abrupt, divides for a linear
// or cubic ramp, using the 64-step serial divider and the single read port
// reset is synchronous; the interval table is not cleared
// a result waits in the output register while the next word is taken
module timed_switch_resistance_profile
  import tsrp_pkg::*;
#(
  parameter int MAX_INTERVALS = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [51:0] cfg_wdata,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  cmd_t cmd;
  sts_t sts;

  tsrp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_word.op),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  tsrp_datapath #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

>>> design/tsrp_checker.sv
// ----------------------------------------------------------------------------
// tsrp_checker
// port-level checks of the timed switch resistance profile
// ----------------------------------------------------------------------------
`include "timed_switch_resistance_profile_assert.svh"

module tsrp_checker
  import tsrp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  `TSRP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `TSRP_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_word))
  `TSRP_ASSERT_NEXT(a_eval_busy, clk, rst_n, in_valid && !in_stall && in_word.op == OP_EVAL, in_stall)
  `TSRP_ASSERT_NEXT(a_load_free, clk, rst_n, in_valid && !in_stall && in_word.op == OP_LOAD, !in_stall)

endmodule

bind timed_switch_resistance_profile tsrp_checker u_tsrp_checker (.*);
